### src/qclt_pkg.sv
package qclt_pkg;

    localparam int MaxResults = 3;

    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChAmp       = 8'h26;
    localparam logic [7:0] ChSquote    = 8'h27;
    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChPipe      = 8'h7c;

    localparam logic KindChar = 1'b0;
    localparam logic KindEol  = 1'b1;

    typedef enum logic [2:0] {
        EV_LIT    = 3'd0,
        EV_TOKEND = 3'd1,
        EV_AND    = 3'd2,
        EV_PIPE   = 3'd3,
        EV_OK     = 3'd4,
        EV_UNTERM = 3'd5
    } qclt_event_t;

    typedef struct packed {
        logic in_single_quote;
        logic in_double_quote;
        logic escape_pending;
        logic token_open;
        logic ampersand_held;
    } qclt_state_t;

    typedef struct packed {
        qclt_event_t ev;
        logic [7:0]  data;
    } qclt_result_t;

    typedef struct packed {
        qclt_result_t [MaxResults-1:0] res;
        logic [1:0]                    count;
    } qclt_batch_t;

endpackage

### src/qclt_decode.sv
module qclt_decode (
    input  qclt_pkg::qclt_state_t state_cur,
    input  logic                  kind,
    input  logic [7:0]            ch,
    output qclt_pkg::qclt_state_t state_nxt,
    output qclt_pkg::qclt_batch_t batch
);
    import qclt_pkg::*;

    always_comb
    begin
        qclt_state_t st;
        logic [1:0]  n;
        logic        do_plain;

        st = state_cur;
        n = 2'd0;
        do_plain = 1'b0;
        batch = '0;

        if (kind == KindChar)
        begin
            do_plain = 1'b1;
            if (st.ampersand_held)
            begin
                st.ampersand_held = 1'b0;
                if (ch == ChAmp)
                begin
                    do_plain = 1'b0;
                    if (st.token_open)
                    begin
                        batch.res[n] = '{ev: EV_TOKEND, data: 8'h00};
                        n = n + 2'd1;
                        st.token_open = 1'b0;
                    end
                    batch.res[n] = '{ev: EV_AND, data: 8'h00};
                    n = n + 2'd1;
                end
                else
                begin
                    // release the held ampersand as a literal
                    batch.res[n] = '{ev: EV_LIT, data: ChAmp};
                    n = n + 2'd1;
                    st.token_open = 1'b1;
                end
            end
            if (do_plain)
            begin
                priority if (st.escape_pending)
                begin
                    st.escape_pending = 1'b0;
                    batch.res[n] = '{ev: EV_LIT, data: ch};
                    n = n + 2'd1;
                    st.token_open = 1'b1;
                end
                else if (ch == ChSquote && !st.in_double_quote)
                begin
                    st.in_single_quote = !st.in_single_quote;
                    st.token_open = 1'b1;
                end
                else if (ch == ChDquote && !st.in_single_quote)
                begin
                    st.in_double_quote = !st.in_double_quote;
                    st.token_open = 1'b1;
                end
                else if (st.in_single_quote || st.in_double_quote)
                begin
                    batch.res[n] = '{ev: EV_LIT, data: ch};
                    n = n + 2'd1;
                    st.token_open = 1'b1;
                end
                else if (ch == ChBackslash)
                begin
                    st.escape_pending = 1'b1;
                end
                else if (ch == ChAmp)
                begin
                    st.ampersand_held = 1'b1;
                end
                else if (ch == ChPipe || ch == ChSpace)
                begin
                    if (st.token_open)
                    begin
                        batch.res[n] = '{ev: EV_TOKEND, data: 8'h00};
                        n = n + 2'd1;
                        st.token_open = 1'b0;
                    end
                    if (ch == ChPipe)
                    begin
                        batch.res[n] = '{ev: EV_PIPE, data: 8'h00};
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    batch.res[n] = '{ev: EV_LIT, data: ch};
                    n = n + 2'd1;
                    st.token_open = 1'b1;
                end
            end
        end
        else
        begin
            if (st.ampersand_held)
            begin
                batch.res[n] = '{ev: EV_LIT, data: ChAmp};
                n = n + 2'd1;
                st.token_open = 1'b1;
            end
            if (st.in_single_quote || st.in_double_quote)
            begin
                batch.res[n] = '{ev: EV_UNTERM, data: 8'h00};
                n = n + 2'd1;
            end
            else
            begin
                if (st.token_open)
                begin
                    batch.res[n] = '{ev: EV_TOKEND, data: 8'h00};
                    n = n + 2'd1;
                end
                batch.res[n] = '{ev: EV_OK, data: 8'h00};
                n = n + 2'd1;
            end
            st = '0;
        end

        batch.count = n;
        state_nxt = st;
    end

endmodule

### src/qclt_emit.sv
module qclt_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  qclt_pkg::qclt_batch_t batch,
    output logic                  load_ok,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte
    output logic [2:0]            m_tuser,   // event_res
    output logic                  m_tlast    // last
);
    import qclt_pkg::*;

    qclt_result_t [MaxResults-1:0] ent_reg, ent_next;
    logic [MaxResults-1:0]         last_reg, last_next;
    logic [1:0]                    count_reg, count_next;
    logic                          xfer;

    assign m_tvalid = (count_reg != 2'd0);
    assign xfer     = m_tvalid && m_tready;
    // empty, or the one remaining result leaves this cycle
    assign load_ok  = (count_reg == 2'd0) || (count_reg == 2'd1 && xfer);

    assign m_tdata = ent_reg[0].data;
    assign m_tuser = ent_reg[0].ev;
    assign m_tlast = last_reg[0];

    always_comb
    begin
        ent_next   = ent_reg;
        last_next  = last_reg;
        count_next = count_reg;
        if (load && load_ok)
        begin
            ent_next   = batch.res;
            count_next = batch.count;
            for (int i = 0; i < MaxResults; i++)
            begin
                last_next[i] = (i == int'(batch.count) - 1);
            end
        end
        else if (xfer)
        begin
            for (int i = 0; i < MaxResults - 1; i++)
            begin
                ent_next[i]  = ent_reg[i+1];
                last_next[i] = last_reg[i+1];
            end
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        last_reg <= last_next;
    end

endmodule

### src/quoted_command_line_tokenizer.sv
// quoted command line tokenizer
// path: input transfer -> input register -> result register -> master side
// throughput: one input transfer per cycle for bytes with at most one result while
//   m_tready is high; an item with several results (up to 3) makes the next item wait
// reset: rst_n asynchronous active low clears quote, escape, token and ampersand flags
//   and empties the input and result registers
module quoted_command_line_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // ch
    input  logic       s_tuser,    // kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [2:0] m_tuser,    // event_res
    output logic       m_tlast     // last
);
    import qclt_pkg::*;

    // input register: one held command line item
    logic        in_valid_reg, in_valid_next;
    logic        kind_reg;
    logic [7:0]  ch_reg;

    // tokenizer flags, updated when the held item is handed to the result stage
    qclt_state_t state_reg, state_next, state_dec;
    qclt_batch_t batch;

    logic load_ok;
    logic take;

    qclt_decode u_decode (
        .state_cur (state_reg),
        .kind      (kind_reg),
        .ch        (ch_reg),
        .state_nxt (state_dec),
        .batch     (batch)
    );

    // items with no results (quotes, backslash, newly held '&') retire at once;
    // others wait until the result register can take the whole batch
    assign take     = in_valid_reg && ((batch.count == 2'd0) || load_ok);
    assign s_tready = !in_valid_reg || take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        state_next    = state_reg;
        if (take)
        begin
            state_next    = state_dec;
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    // payload capture on each input transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            ch_reg   <= s_tdata;
        end
    end

    // result register with serializer for multi-result items
    qclt_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .batch    (batch),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
